// File: src/convex_support_point_search_macros.svh
`ifndef CONVEX_SUPPORT_POINT_SEARCH_MACROS_SVH
`define CONVEX_SUPPORT_POINT_SEARCH_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CSPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CSPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cssp_pkg.sv
package cssp_pkg;

  // Item kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // What the shared multiplier is working on
  typedef enum logic [2:0] {
    GRP_QUAT,
    GRP_ROT,
    GRP_SCORE,
    GRP_SQ,
    GRP_BIAS
  } mul_grp_e;

  typedef struct packed {
    logic     clr;
    logic     app;
    logic     start;
    logic     build_r;
    logic     load;
    logic     mul_en;
    mul_grp_e grp;
    logic [3:0] j;
    logic [1:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_done;
    logic sqrt_busy;
    logic div_busy;
    logic len_zero;
  } dp_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7fff_ffff) return 32'sh7fff_ffff;
    if (v < -64'sh0000_0000_8000_0000) return -32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

// File: src/cssp_dp.sv
module cssp_dp #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cssp_pkg::dp_cmd_t    cmd_i,
  output cssp_pkg::dp_sts_t    sts_o,
  input  logic signed [31:0]   vec_x_i,
  input  logic signed [31:0]   vec_y_i,
  input  logic signed [31:0]   vec_z_i,
  input  logic signed [31:0]   quat_w_i,
  input  logic signed [31:0]   quat_x_i,
  input  logic signed [31:0]   quat_y_i,
  input  logic signed [31:0]   quat_z_i,
  input  logic signed [31:0]   bias_i,
  output logic signed [31:0]   sup_x_o,
  output logic signed [31:0]   sup_y_o,
  output logic signed [31:0]   sup_z_o,
  output logic [5:0]           idx_o,
  output logic                 empty_o,
  output logic                 ovf_o
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam logic signed [37:0] ONE = 38'sd1073741824;

  // Vertex store
  logic signed [31:0] mem_x [MAX_VERTICES];
  logic signed [31:0] mem_y [MAX_VERTICES];
  logic signed [31:0] mem_z [MAX_VERTICES];

  logic [CW-1:0] count_q, vi_q;
  logic          ovf_q, full;
  logic [AW-1:0] cand_q, best_idx_q;

  // Query operands and intermediates
  logic signed [31:0] d_q [3];
  logic signed [31:0] q_q [4];
  logic signed [31:0] bias_q;
  logic signed [33:0] qp_q [9];
  logic signed [31:0] r_q [3][3];
  logic signed [31:0] rb [3][3];
  logic signed [37:0] e [9];
  logic signed [31:0] s_q [3];
  logic signed [31:0] p_q [3];
  logic signed [31:0] best_p_q [3];
  logic signed [35:0] acc_q, acc_sum;
  logic signed [63:0] sc_q, sc_sum, best_sc_q;

  // Shared multiplier
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] mul_res, prod_q, rnd30_t, rnd2_t;
  logic signed [33:0] rnd30;
  logic signed [61:0] rnd2;
  logic [63:0]        prod_mag, n_sum;
  logic               mul_v_q;
  cssp_pkg::mul_grp_e tg_grp_q;
  logic [3:0]         tg_j_q;
  logic [1:0]         tg_k_q;
  logic               tag_sq_last, tag_bias;

  // Square root and divider
  logic [63:0] n_q, res_q, bit_q, sq_t;
  logic        sq_ge, sq_busy_q;
  logic [63:0] dq_q;
  logic [31:0] rem_q;
  logic [32:0] rem_sh, rem_sub;
  logic        d_ge, div_busy_q, neg_q;
  logic [6:0]  dcnt_q;
  logic [1:0]  dj_q;
  logic signed [63:0] push, fsum;

  assign full = (count_q == CW'(MAX_VERTICES));

  // Operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.grp)
      cssp_pkg::GRP_QUAT: begin
        case (cmd_i.j)
          4'd0: begin op_a = q_q[1]; op_b = q_q[1]; end
          4'd1: begin op_a = q_q[2]; op_b = q_q[2]; end
          4'd2: begin op_a = q_q[3]; op_b = q_q[3]; end
          4'd3: begin op_a = q_q[1]; op_b = q_q[2]; end
          4'd4: begin op_a = q_q[1]; op_b = q_q[3]; end
          4'd5: begin op_a = q_q[2]; op_b = q_q[3]; end
          4'd6: begin op_a = q_q[0]; op_b = q_q[1]; end
          4'd7: begin op_a = q_q[0]; op_b = q_q[2]; end
          4'd8: begin op_a = q_q[0]; op_b = q_q[3]; end
          default: begin op_a = '0; op_b = '0; end
        endcase
      end
      cssp_pkg::GRP_ROT: begin
        op_a = r_q[cmd_i.j[1:0]][cmd_i.k];
        op_b = s_q[cmd_i.k];
      end
      cssp_pkg::GRP_SCORE: begin
        op_a = d_q[cmd_i.j[1:0]];
        op_b = p_q[cmd_i.j[1:0]];
      end
      cssp_pkg::GRP_SQ: begin
        op_a = best_p_q[cmd_i.j[1:0]];
        op_b = best_p_q[cmd_i.j[1:0]];
      end
      cssp_pkg::GRP_BIAS: begin
        op_a = best_p_q[cmd_i.j[1:0]];
        op_b = bias_q;
      end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign mul_res = op_a * op_b;

  // Rounding and accumulation of the registered product
  assign rnd30_t  = prod_q + 64'sd536870912;
  assign rnd30    = rnd30_t[63:30];
  assign rnd2_t   = prod_q + 64'sd2;
  assign rnd2     = rnd2_t[63:2];
  assign acc_sum  = ((tg_k_q == 2'd0) ? 36'sd0 : acc_q) + 36'(rnd30);
  assign sc_sum   = ((tg_j_q == 4'd0) ? 64'sd0 : sc_q) + 64'(rnd2);
  assign n_sum    = ((tg_j_q == 4'd0) ? 64'd0 : n_q) + $unsigned(prod_q);
  assign prod_mag = prod_q[63] ? $unsigned(-prod_q) : $unsigned(prod_q);

  assign tag_sq_last = mul_v_q && (tg_grp_q == cssp_pkg::GRP_SQ) && (tg_j_q == 4'd2);
  assign tag_bias    = mul_v_q && (tg_grp_q == cssp_pkg::GRP_BIAS);

  // Rotation matrix from the quaternion products
  always_comb begin
    for (int i = 0; i < 9; i++) e[i] = 38'(qp_q[i]);
    rb[0][0] = cssp_pkg::sat32(64'(ONE - 38'sd2 * (e[1] + e[2])));
    rb[0][1] = cssp_pkg::sat32(64'(38'sd2 * (e[3] - e[8])));
    rb[0][2] = cssp_pkg::sat32(64'(38'sd2 * (e[4] + e[7])));
    rb[1][0] = cssp_pkg::sat32(64'(38'sd2 * (e[3] + e[8])));
    rb[1][1] = cssp_pkg::sat32(64'(ONE - 38'sd2 * (e[0] + e[2])));
    rb[1][2] = cssp_pkg::sat32(64'(38'sd2 * (e[5] - e[6])));
    rb[2][0] = cssp_pkg::sat32(64'(38'sd2 * (e[4] - e[7])));
    rb[2][1] = cssp_pkg::sat32(64'(38'sd2 * (e[5] + e[6])));
    rb[2][2] = cssp_pkg::sat32(64'(ONE - 38'sd2 * (e[0] + e[1])));
  end

  // Square root step, divider step and final push
  assign sq_t    = res_q + bit_q;
  assign sq_ge   = (n_q >= sq_t);
  assign rem_sh  = {rem_q, dq_q[63]};
  assign d_ge    = (rem_sh >= {1'b0, res_q[31:0]});
  assign rem_sub = rem_sh - {1'b0, res_q[31:0]};
  assign push    = neg_q ? -$signed(dq_q) : $signed(dq_q);
  assign fsum    = 64'(best_p_q[dj_q]) + push;

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.app && !full) begin
      mem_x[count_q[AW-1:0]] <= vec_x_i;
      mem_y[count_q[AW-1:0]] <= vec_y_i;
      mem_z[count_q[AW-1:0]] <= vec_z_i;
    end
    if (cmd_i.load) begin
      s_q[0] <= mem_x[vi_q[AW-1:0]];
      s_q[1] <= mem_y[vi_q[AW-1:0]];
      s_q[2] <= mem_z[vi_q[AW-1:0]];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      ovf_q      <= 1'b0;
      vi_q       <= '0;
      mul_v_q    <= 1'b0;
      sq_busy_q  <= 1'b0;
      div_busy_q <= 1'b0;
      dcnt_q     <= '0;
    end else begin
      if (cmd_i.clr) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.app) begin
        if (full) ovf_q <= 1'b1;
        else      count_q <= count_q + CW'(1);
      end
      if (cmd_i.start)     vi_q <= '0;
      else if (cmd_i.load) vi_q <= vi_q + CW'(1);
      mul_v_q <= cmd_i.mul_en;
      if (tag_sq_last)                 sq_busy_q <= 1'b1;
      else if (sq_busy_q && bit_q[0])  sq_busy_q <= 1'b0;
      if (tag_bias) begin
        div_busy_q <= 1'b1;
        dcnt_q     <= '0;
      end else if (div_busy_q) begin
        if (dcnt_q[6]) div_busy_q <= 1'b0;
        dcnt_q <= dcnt_q + 7'd1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      d_q[0] <= vec_x_i;
      d_q[1] <= vec_y_i;
      d_q[2] <= vec_z_i;
      q_q[0] <= quat_w_i;
      q_q[1] <= quat_x_i;
      q_q[2] <= quat_y_i;
      q_q[3] <= quat_z_i;
      bias_q <= bias_i;
      for (int i = 0; i < 3; i++) best_p_q[i] <= '0;
      best_idx_q <= '0;
    end
    if (cmd_i.build_r) r_q <= rb;
    if (cmd_i.load) cand_q <= vi_q[AW-1:0];
    if (cmd_i.mul_en) begin
      prod_q   <= mul_res;
      tg_grp_q <= cmd_i.grp;
      tg_j_q   <= cmd_i.j;
      tg_k_q   <= cmd_i.k;
    end

    // consume the product
    if (mul_v_q) begin
      case (tg_grp_q)
        cssp_pkg::GRP_QUAT: qp_q[tg_j_q] <= rnd30;
        cssp_pkg::GRP_ROT: begin
          if (tg_k_q == 2'd2) p_q[tg_j_q[1:0]] <= cssp_pkg::sat32(64'(acc_sum));
          else                acc_q <= acc_sum;
        end
        cssp_pkg::GRP_SCORE: begin
          if (tg_j_q == 4'd2) begin
            // first vertex always taken, later ones on a strict gain
            if (cand_q == '0 || sc_sum > best_sc_q) begin
              best_sc_q  <= sc_sum;
              best_idx_q <= cand_q;
              best_p_q   <= p_q;
            end
          end else begin
            sc_q <= sc_sum;
          end
        end
        cssp_pkg::GRP_SQ: begin
          n_q <= n_sum;
          if (tg_j_q == 4'd2) begin
            res_q <= '0;
            bit_q <= 64'h4000_0000_0000_0000;
          end
        end
        cssp_pkg::GRP_BIAS: begin
          dq_q  <= prod_mag;
          rem_q <= '0;
          neg_q <= prod_q[63];
          dj_q  <= tg_j_q[1:0];
        end
        default: ;
      endcase
    end

    // integer square root, two bits of radicand a cycle
    if (sq_busy_q) begin
      if (sq_ge) begin
        n_q   <= n_q - sq_t;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end

    // restoring divide, one quotient bit a cycle, then apply the push
    if (div_busy_q) begin
      if (!dcnt_q[6]) begin
        dq_q  <= {dq_q[62:0], d_ge};
        rem_q <= d_ge ? rem_sub[31:0] : rem_sh[31:0];
      end else begin
        best_p_q[dj_q] <= cssp_pkg::sat32(fsum);
      end
    end
  end

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.scan_done  = (vi_q == count_q);
  assign sts_o.sqrt_busy  = sq_busy_q;
  assign sts_o.div_busy   = div_busy_q;
  assign sts_o.len_zero   = (res_q[31:0] == '0);

  assign sup_x_o = best_p_q[0];
  assign sup_y_o = best_p_q[1];
  assign sup_z_o = best_p_q[2];
  assign idx_o   = 6'(best_idx_q);
  assign empty_o = (count_q == '0);
  assign ovf_o   = ovf_q;

endmodule

// File: src/cssp_ctrl.sv
module cssp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         kind_i,
  output logic               in_stall_o,
  output cssp_pkg::dp_cmd_t  cmd_o,
  input  cssp_pkg::dp_sts_t  sts_i,
  input  logic               out_free_i,
  output logic               out_load_o
);

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_ROT   = 15'b000000000000010,
    ST_RWAIT = 15'b000000000000100,
    ST_RBLD  = 15'b000000000001000,
    ST_LOAD  = 15'b000000000010000,
    ST_VROT  = 15'b000000000100000,
    ST_VSC   = 15'b000000001000000,
    ST_SWAIT = 15'b000000010000000,
    ST_SQM   = 15'b000000100000000,
    ST_SQW   = 15'b000001000000000,
    ST_SQRT  = 15'b000010000000000,
    ST_BMUL  = 15'b000100000000000,
    ST_BW    = 15'b001000000000000,
    ST_DIV   = 15'b010000000000000,
    ST_DONE  = 15'b100000000000000
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] cj_q, cj_d;
  logic [1:0] ck_q, ck_d;

  // Sequencing
  always_comb begin
    state_d    = state_q;
    cj_d       = cj_q;
    ck_d       = ck_q;
    cmd_o      = '0;
    cmd_o.j    = cj_q;
    cmd_o.k    = ck_q;
    in_stall_o = 1'b1;
    out_load_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (kind_i)
            cssp_pkg::KIND_CLEAR:  cmd_o.clr = 1'b1;
            cssp_pkg::KIND_APPEND: cmd_o.app = 1'b1;
            cssp_pkg::KIND_QUERY: begin
              cmd_o.start = 1'b1;
              cj_d        = '0;
              state_d     = sts_i.count_zero ? ST_DONE : ST_ROT;
            end
            default: ;
          endcase
        end
      end
      ST_ROT: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.grp    = cssp_pkg::GRP_QUAT;
        if (cj_q == 4'd8) state_d = ST_RWAIT;
        else              cj_d = cj_q + 4'd1;
      end
      ST_RWAIT: state_d = ST_RBLD;
      ST_RBLD: begin
        cmd_o.build_r = 1'b1;
        state_d       = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        cj_d       = '0;
        ck_d       = '0;
        state_d    = ST_VROT;
      end
      ST_VROT: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.grp    = cssp_pkg::GRP_ROT;
        if (ck_q == 2'd2) begin
          ck_d = '0;
          if (cj_q == 4'd2) begin
            cj_d    = '0;
            state_d = ST_VSC;
          end else begin
            cj_d = cj_q + 4'd1;
          end
        end else begin
          ck_d = ck_q + 2'd1;
        end
      end
      ST_VSC: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.grp    = cssp_pkg::GRP_SCORE;
        if (cj_q == 4'd2) begin
          cj_d    = '0;
          state_d = sts_i.scan_done ? ST_SWAIT : ST_LOAD;
        end else begin
          cj_d = cj_q + 4'd1;
        end
      end
      ST_SWAIT: state_d = ST_SQM;
      ST_SQM: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.grp    = cssp_pkg::GRP_SQ;
        if (cj_q == 4'd2) begin
          cj_d    = '0;
          state_d = ST_SQW;
        end else begin
          cj_d = cj_q + 4'd1;
        end
      end
      ST_SQW: state_d = ST_SQRT;
      ST_SQRT: begin
        if (!sts_i.sqrt_busy) begin
          cj_d    = '0;
          state_d = sts_i.len_zero ? ST_DONE : ST_BMUL;
        end
      end
      ST_BMUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.grp    = cssp_pkg::GRP_BIAS;
        state_d      = ST_BW;
      end
      ST_BW: state_d = ST_DIV;
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          if (cj_q == 4'd2) begin
            state_d = ST_DONE;
          end else begin
            cj_d    = cj_q + 4'd1;
            state_d = ST_BMUL;
          end
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cj_q    <= '0;
      ck_q    <= '0;
    end else begin
      state_q <= state_d;
      cj_q    <= cj_d;
      ck_q    <= ck_d;
    end
  end

endmodule

// File: src/convex_support_point_search.sv
// Support point search over a stored vertex cloud.
// Input channel (in_valid_i / in_stall_o) takes one word per item: kind_i
// selects clear, append or query; vec_*_i carries the vertex or direction,
// quat_*_i the orientation and bias_i the outward push. Clear and append
// give no result. A query gives one result word on the output channel
// (out_valid_o / out_stall_i). One 32x32 multiplier is shared by every
// product: 9 for the rotation, 12 per vertex and 6 for the final push;
// the vertex length comes from a 32-step square root and each push from
// a 64-step divider. An empty store skips the search, and a winning vertex
// of zero length skips the push.
// One item is worked on at a time; in_stall_o is high while a query runs.
// A finished result sits in the output register, so the next item is taken
// while the receiver stalls; a further query waits for that register.
// Reset empties the store, clears the overflow flag and drops any result.
`include "convex_support_point_search_macros.svh"

module convex_support_point_search #(
  parameter int MAX_VERTICES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [31:0] quat_w_i,
  input  logic signed [31:0] quat_x_i,
  input  logic signed [31:0] quat_y_i,
  input  logic signed [31:0] quat_z_i,
  input  logic signed [31:0] bias_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] support_x_o,
  output logic signed [31:0] support_y_o,
  output logic signed [31:0] support_z_o,
  output logic [5:0]         best_index_o,
  output logic               store_empty_o,
  output logic               overflowed_o
);

  cssp_pkg::dp_cmd_t  cmd;
  cssp_pkg::dp_sts_t  sts;
  logic               out_load, out_free, out_valid_q;
  logic signed [31:0] sup_x, sup_y, sup_z;
  logic [5:0]         idx;
  logic               empty, ovf;

  cssp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts),
    .out_free_i (out_free),
    .out_load_o (out_load)
  );

  cssp_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .vec_x_i  (vec_x_i),
    .vec_y_i  (vec_y_i),
    .vec_z_i  (vec_z_i),
    .quat_w_i (quat_w_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .bias_i   (bias_i),
    .sup_x_o  (sup_x),
    .sup_y_o  (sup_y),
    .sup_z_o  (sup_z),
    .idx_o    (idx),
    .empty_o  (empty),
    .ovf_o    (ovf)
  );

  // Output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      support_x_o   <= sup_x;
      support_y_o   <= sup_y;
      support_z_o   <= sup_z;
      best_index_o  <= idx;
      store_empty_o <= empty;
      overflowed_o  <= ovf;
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks
  `CSPS_ASSERT_IMP(a_no_overwrite, out_load && out_valid_q, !out_stall_i, "result overwritten")
  `CSPS_ASSERT_IMP(a_empty_zero, out_valid_o && store_empty_o, support_x_o == 0 && support_y_o == 0 && support_z_o == 0 && best_index_o == 0, "empty store gave nonzero result")
  `CSPS_ASSERT_IMP(a_units_excl, 1'b1, !(sts.sqrt_busy && sts.div_busy), "sqrt and divider both busy")
  `CSPS_ASSERT_NXT(a_query_busy, in_valid_i && !in_stall_o && kind_i == cssp_pkg::KIND_QUERY, in_stall_o, "query did not stall input")

endmodule
